// ===== src/sat_pkg.sv =====
package sat_pkg;

  localparam int unsigned KIND_W     = 2;
  localparam int unsigned TAG_W      = 32;
  localparam int unsigned SLOT_OUT_W = 6;
  localparam int unsigned STATUS_W   = 3;
  localparam int unsigned FREE_W     = 7;

  typedef enum logic [KIND_W-1:0] {
    KIND_LOOKUP  = 2'd0,
    KIND_RELEASE = 2'd1,
    KIND_CLEAR   = 2'd2
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_HIT     = 3'd0,
    STAT_ALLOC   = 3'd1,
    STAT_FULL    = 3'd2,
    STAT_MISSING = 3'd3,
    STAT_DONE    = 3'd4
  } status_t;

  // broadcast control from the sequencer to every cell
  typedef struct packed {
    logic             cmp;
    logic             clear;
    logic             bind_en;
    logic             unbind;
    logic [TAG_W-1:0] cmp_tag;
    logic [TAG_W-1:0] bind_tag;
  } cell_ctl_t;

endpackage

// ===== src/sat_if.sv =====
interface sat_in_if;
  logic                       valid;
  logic                       ready;
  logic [sat_pkg::KIND_W-1:0] kind;
  logic [sat_pkg::TAG_W-1:0]  owner_tag;

  modport source (output valid, output kind, output owner_tag, input ready);
  modport sink   (input valid, input kind, input owner_tag, output ready);
endinterface

interface sat_out_if;
  logic                           valid;
  logic                           ready;
  logic [sat_pkg::SLOT_OUT_W-1:0] slot_index;
  logic [sat_pkg::STATUS_W-1:0]   status;
  logic [sat_pkg::FREE_W-1:0]     free_slots;

  modport source (output valid, output slot_index, output status, output free_slots,
                  input ready);
  modport sink   (input valid, input slot_index, input status, input free_slots,
                  output ready);
endinterface

// ===== src/slot_allocator_with_tag_map.sv =====
// a result enters the output register in the resolve state, once it is empty;
// items are taken only while idle, so none until the last resolves; accepting
// compares the tag in every cell and reads the free queue head, resolving updates
// the queue; a waiting result blocks the next item only in its resolve state
// reset: synchronous, active low; all slots free, queue reads 0..SLOTS-1 by way
// of a fill count, so no clearing pass is needed after reset or clear-all
module slot_allocator_with_tag_map #(
  parameter int unsigned SLOTS = 64
) (
  input  logic            clk,
  input  logic            rst_n,
  sat_in_if.sink          in_ch,
  sat_out_if.source       out_ch
);

  localparam int unsigned IDX_W = $clog2(SLOTS);
  localparam int unsigned CNT_W = $clog2(SLOTS + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(SLOTS);

  typedef enum logic {S_IDLE, S_RESOLVE} state_t;

  state_t                         state_r, state_nxt;
  logic [sat_pkg::KIND_W-1:0]     kind_r;
  logic [sat_pkg::TAG_W-1:0]      tag_r;
  logic [IDX_W-1:0]               head_r, head_nxt;
  logic [IDX_W-1:0]               tail_r, tail_nxt;
  logic [CNT_W-1:0]               count_r, count_nxt;
  logic [CNT_W-1:0]               fill_r, fill_nxt;
  logic                           out_valid_r, out_valid_nxt;
  logic [sat_pkg::SLOT_OUT_W-1:0] out_slot_r, out_slot_nxt;
  logic [sat_pkg::STATUS_W-1:0]   out_status_r, out_status_nxt;
  logic [sat_pkg::FREE_W-1:0]     out_free_r, out_free_nxt;

  logic [IDX_W-1:0]               queue_mem [SLOTS];
  logic [IDX_W-1:0]               q_data_r;
  logic                           q_written_r;
  logic                           q_wr;
  logic [IDX_W-1:0]               q_wr_data;

  logic                           accept;
  logic                           load;
  logic [SLOTS-1:0]               match;
  logic                           hit;
  logic [IDX_W-1:0]               hit_idx;
  logic [IDX_W-1:0]               q_slot;
  logic [IDX_W-1:0]               sel_idx;
  sat_pkg::cell_ctl_t             ctl;

  function automatic logic [IDX_W-1:0] wrap_next(input logic [IDX_W-1:0] p);
    wrap_next = (p == LAST_IDX) ? '0 : p + 1'b1;
  endfunction

  assign accept = in_ch.valid && in_ch.ready;
  assign load   = (state_r == S_RESOLVE) && (!out_valid_r || out_ch.ready);

  // a tag is bound to at most one slot, so an or of the indices encodes the hit
  always_comb begin
    hit_idx = '0;
    for (int unsigned i = 0; i < SLOTS; i++) begin
      if (match[i]) begin
        hit_idx = hit_idx | IDX_W'(i);
      end
    end
  end

  assign hit    = |match;
  assign q_slot = q_written_r ? q_data_r : head_r;

  always_comb begin
    state_nxt      = state_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    count_nxt      = count_r;
    fill_nxt       = fill_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_slot_nxt   = out_slot_r;
    out_status_nxt = out_status_r;
    out_free_nxt   = out_free_r;
    q_wr           = 1'b0;
    q_wr_data      = hit_idx;
    sel_idx        = hit_idx;
    ctl.cmp        = accept;
    ctl.cmp_tag    = in_ch.owner_tag;
    ctl.bind_tag   = tag_r;
    ctl.clear      = 1'b0;
    ctl.bind_en    = 1'b0;
    ctl.unbind     = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_RESOLVE;
        end
      end
      S_RESOLVE: begin
        if (load) begin
          state_nxt      = S_IDLE;
          out_valid_nxt  = 1'b1;
          out_slot_nxt   = '0;
          out_status_nxt = sat_pkg::STAT_MISSING;
          unique case (kind_r)
            sat_pkg::KIND_LOOKUP: begin
              if (hit) begin
                out_slot_nxt   = sat_pkg::SLOT_OUT_W'(hit_idx);
                out_status_nxt = sat_pkg::STAT_HIT;
              end else if (count_r == '0) begin
                out_status_nxt = sat_pkg::STAT_FULL;
              end else begin
                sel_idx        = q_slot;
                ctl.bind_en    = 1'b1;
                head_nxt       = wrap_next(head_r);
                count_nxt      = count_r - 1'b1;
                out_slot_nxt   = sat_pkg::SLOT_OUT_W'(q_slot);
                out_status_nxt = sat_pkg::STAT_ALLOC;
              end
            end
            sat_pkg::KIND_RELEASE: begin
              if (hit) begin
                ctl.unbind = 1'b1;
                if (count_r < FULL_CNT) begin
                  q_wr      = 1'b1;
                  tail_nxt  = wrap_next(tail_r);
                  count_nxt = count_r + 1'b1;
                  if (fill_r < FULL_CNT) begin
                    fill_nxt = fill_r + 1'b1;
                  end
                end
                out_slot_nxt   = sat_pkg::SLOT_OUT_W'(hit_idx);
                out_status_nxt = sat_pkg::STAT_DONE;
              end
            end
            sat_pkg::KIND_CLEAR: begin
              ctl.clear      = 1'b1;
              head_nxt       = '0;
              tail_nxt       = '0;
              count_nxt      = FULL_CNT;
              fill_nxt       = '0;
              out_status_nxt = sat_pkg::STAT_DONE;
            end
            default: begin
              out_status_nxt = sat_pkg::STAT_MISSING;
            end
          endcase
          out_free_nxt = sat_pkg::FREE_W'(count_nxt);
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= FULL_CNT;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      count_r     <= count_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_slot_r   <= out_slot_nxt;
    out_status_r <= out_status_nxt;
    out_free_r   <= out_free_nxt;
    if (accept) begin
      kind_r <= in_ch.kind;
      tag_r  <= in_ch.owner_tag;
    end
  end

  // free queue; entries at or past the fill count read as their own index
  always_ff @(posedge clk) begin
    if (q_wr) begin
      queue_mem[tail_r] <= q_wr_data;
    end
    if (accept) begin
      q_data_r    <= queue_mem[head_r];
      q_written_r <= CNT_W'(head_r) < fill_r;
    end
  end

  for (genvar g = 0; g < SLOTS; g++) begin : g_cell
    sat_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .ctl   (ctl),
      .sel   (sel_idx == IDX_W'(g)),
      .match (match[g])
    );
  end

  assign in_ch.ready       = (state_r == S_IDLE);
  assign out_ch.valid      = out_valid_r;
  assign out_ch.slot_index = out_slot_r;
  assign out_ch.status     = out_status_r;
  assign out_ch.free_slots = out_free_r;

endmodule

// ===== src/sat_cell.sv =====
module sat_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  sat_pkg::cell_ctl_t ctl,
  input  logic               sel,
  output logic               match
);

  logic                      in_use_r;
  logic                      in_use_nxt;
  logic [sat_pkg::TAG_W-1:0] owner_r;
  logic                      match_r;

  always_comb begin
    in_use_nxt = in_use_r;
    if (ctl.clear) begin
      in_use_nxt = 1'b0;
    end else if (sel && ctl.bind_en) begin
      in_use_nxt = 1'b1;
    end else if (sel && ctl.unbind) begin
      in_use_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_use_r <= 1'b0;
      match_r  <= 1'b0;
    end else begin
      in_use_r <= in_use_nxt;
      if (ctl.cmp) begin
        match_r <= in_use_r && (owner_r == ctl.cmp_tag);
      end
    end
  end

  // owner only read while in use
  always_ff @(posedge clk) begin
    if (sel && ctl.bind_en && !ctl.clear) begin
      owner_r <= ctl.bind_tag;
    end
  end

  assign match = match_r;

endmodule

// ===== src/sat_checker.sv =====
module sat_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [sat_pkg::SLOT_OUT_W-1:0] out_slot_index,
  input logic [sat_pkg::STATUS_W-1:0]   out_status,
  input logic [sat_pkg::FREE_W-1:0]     out_free_slots
);

  // an item keeps the input closed for its resolve cycle
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("item accepted in consecutive cycles");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before it was taken");

  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status <= sat_pkg::STAT_DONE)
    else $error("status code out of range");

  a_full_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == sat_pkg::STAT_FULL) |-> out_free_slots == '0)
    else $error("no free slot flagged with slots left");

  a_none_slot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == sat_pkg::STAT_FULL || out_status == sat_pkg::STAT_MISSING)
      |-> out_slot_index == '0)
    else $error("slot index given for a failed item");

endmodule

bind slot_allocator_with_tag_map sat_checker u_sat_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_slot_index (out_ch.slot_index),
  .out_status     (out_ch.status),
  .out_free_slots (out_ch.free_slots)
);
